/* sv/itf_pkg.sv */
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types and constants for the integer text formatter.
// ----------------------------------------------------------------------------
`default_nettype none
package itf_pkg;

   typedef struct packed {
      logic [63:0] value;
      logic [7:0]  field_width;
      logic [7:0]  min_length;
      logic [4:0]  radix;
      logic        want_prefix;
      logic        is_signed;
      logic        zero_pad;
      logic        left_align;
      logic        show_plus;
      logic        space_sign;
      logic        upper_case;
      logic        is_negative;
   } req_type;

   typedef struct packed {
      logic [63:0] text_chunk;
      logic [3:0]  chunk_count;
      logic        last_chunk;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PLAN,
      ST_EMIT,
      ST_SEND
   } state_type;

   typedef enum logic [2:0] {
      SEG_LEAD,
      SEG_SIGN,
      SEG_PFX0,
      SEG_PFX1,
      SEG_ZERO,
      SEG_DIGIT,
      SEG_TRAIL,
      SEG_DONE
   } seg_type;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      begin
         if (d < 4'd10) c = CH_ZERO + {4'd0, d};
         else if (upper) c = 8'h37 + {4'd0, d};
         else c = 8'h57 + {4'd0, d};
         return c;
      end
   endfunction

endpackage
`default_nettype wire

/* sv/itf_if.sv */
// ----------------------------------------------------------------------------
// itf_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface itf_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* sv/itf_divider.sv */
// ----------------------------------------------------------------------------
// itf_divider
// Restoring divider, one quotient bit per cycle, by a small radix.
// ----------------------------------------------------------------------------
`default_nettype none
module itf_divider #(
   parameter int VALUE_BITS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [VALUE_BITS-1:0] dividend,
   input  wire logic [4:0]            divisor,
   output logic                       done,
   output logic [VALUE_BITS-1:0]      quotient,
   output logic [3:0]                 remainder
);
   localparam int CW = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] q_ff, q_in;
   logic [4:0]            r_ff, r_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic [5:0]            trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {r_ff, q_ff[VALUE_BITS-1]};
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         cnt_in  = CW'(VALUE_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            r_in = 5'(trial - {1'b0, divisor});
            q_in = {q_ff[VALUE_BITS-2:0], 1'b1};
         end else begin
            r_in = trial[4:0];
            q_in = {q_ff[VALUE_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign done      = busy_ff && (cnt_ff == CW'(1));
   assign quotient  = q_in;
   assign remainder = r_in[3:0];
endmodule
`default_nettype wire

/* sv/integer_text_formatter_unit.sv */
// ----------------------------------------------------------------------------
// integer_text_formatter_unit
// Renders an integer as padded ASCII text, sent in chunks.
//
//   channel  dir  payload
//   req      in   value, width, precision, radix and flags
//   rsp      out  text_chunk, chunk_count, last_chunk
//
// Each digit comes from one pass of the bit-serial divider, then the text
// characters are written one by one into the chunk register, and each chunk
// is sent before the next one is filled. A stalled response holds the block;
// one request is in flight at a time. Reset clears control state only.
// ----------------------------------------------------------------------------
`default_nettype none
module integer_text_formatter_unit #(
   parameter int MAX_FIELD   = 255,
   parameter int VALUE_BITS  = 64,
   parameter int CHUNK_CHARS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   itf_if.sink       req,
   itf_if.source     rsp
);
   localparam int FW = $clog2(MAX_FIELD + 1);
   localparam int DW = $clog2(VALUE_BITS + 1);
   localparam int KW = $clog2(CHUNK_CHARS + 1);

   itf_pkg::state_type st_ff, st_in;
   itf_pkg::seg_type   seg_ff, seg_in;
   itf_pkg::req_type   r_ff, r_in;

   logic [VALUE_BITS-1:0] num_ff, num_in;
   logic [4:0]            rad_ff, rad_in;
   logic [4*VALUE_BITS-1:0] dig_ff, dig_in;
   logic [DW-1:0]         nd_ff, nd_in;
   logic [FW-1:0]         cnt_ff, cnt_in;
   logic [FW-1:0]         lead_ff, lead_in, zer_ff, zer_in;
   logic [1:0]            plen_ff, plen_in;
   logic                  sg_ff, sg_in;
   logic [7:0]            sgc_ff, sgc_in;
   logic [63:0]           chunk_ff, chunk_in;
   logic [KW-1:0]         cc_ff, cc_in;
   logic                  last_ff, last_in;
   logic                  go_ff, go_in;

   logic                  dv_start, dv_done;
   logic [VALUE_BITS-1:0] dv_q;
   logic [3:0]            dv_r;

   logic [FW-1:0] w_s, p_s, size_s, prec_s, pad_s;
   logic          zp;
   logic [7:0]    ch;
   logic          put;
   logic [FW-1:0] lim;
   logic          tail_done;

   assign dv_start = go_ff;

   itf_divider #(.VALUE_BITS(VALUE_BITS)) u_div (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(num_ff),
      .divisor(rad_ff), .done(dv_done), .quotient(dv_q), .remainder(dv_r)
   );

   always_comb begin
      w_s = ({1'b0, r_ff.field_width} > 9'(MAX_FIELD)) ? FW'(MAX_FIELD)
            : FW'(r_ff.field_width);
      p_s = ({1'b0, r_ff.min_length} > 9'(MAX_FIELD)) ? FW'(MAX_FIELD)
            : FW'(r_ff.min_length);
      size_s = FW'(nd_ff) + FW'(plen_ff) + FW'(sg_ff);
      zp = r_ff.zero_pad && !r_ff.left_align;
      prec_s = (zp && p_s == '0) ? w_s : p_s;
      if (size_s > prec_s) prec_s = size_s;
      pad_s = (w_s > prec_s) ? FW'(w_s - prec_s) : '0;
   end

   always_comb begin
      st_in = st_ff; seg_in = seg_ff; r_in = r_ff; num_in = num_ff; rad_in = rad_ff;
      dig_in = dig_ff; nd_in = nd_ff; cnt_in = cnt_ff; lead_in = lead_ff;
      zer_in = zer_ff; plen_in = plen_ff; sg_in = sg_ff; sgc_in = sgc_ff;
      chunk_in = chunk_ff; cc_in = cc_ff; last_in = last_ff;
      go_in = 1'b0; ch = itf_pkg::CH_SPACE; put = 1'b0; lim = '0;
      req.ready = (st_ff == itf_pkg::ST_IDLE);
      rsp.valid = (st_ff == itf_pkg::ST_SEND);
      case (st_ff)
         itf_pkg::ST_IDLE: begin
            if (req.valid) begin
               r_in = req.payload;
               num_in = req.payload.value[VALUE_BITS-1:0];
               if (req.payload.radix < 5'd2) rad_in = 5'd2;
               else if (req.payload.radix > 5'd16) rad_in = 5'd16;
               else rad_in = req.payload.radix;
               nd_in = '0;
               go_in = 1'b1;
               st_in = itf_pkg::ST_DIV;
            end
         end
         itf_pkg::ST_DIV: begin
            if (dv_done) begin
               dig_in = {dig_ff[4*VALUE_BITS-5:0], dv_r};
               nd_in = nd_ff + 1'b1;
               num_in = dv_q;
               if (dv_q == '0 || nd_ff == DW'(VALUE_BITS - 1)) begin
                  st_in = itf_pkg::ST_PLAN;
               end else begin
                  go_in = 1'b1;
               end
            end
         end
         itf_pkg::ST_PLAN: begin
            plen_in = 2'd0;
            if (r_ff.want_prefix) begin
               if (rad_ff == 5'd2 || rad_ff == 5'd16) plen_in = 2'd2;
               else if (rad_ff == 5'd8) plen_in = 2'd1;
            end
            sg_in = 1'b0; sgc_in = itf_pkg::CH_SPACE;
            if (r_ff.is_signed) begin
               if (r_ff.is_negative) begin sg_in = 1'b1; sgc_in = itf_pkg::CH_MINUS; end
               else if (r_ff.show_plus) begin sg_in = 1'b1; sgc_in = itf_pkg::CH_PLUS; end
               else if (r_ff.space_sign) sg_in = 1'b1;
            end
            seg_in = itf_pkg::SEG_LEAD; cnt_in = '0;
            cc_in = '0; chunk_in = '0; last_in = 1'b0;
            st_in = itf_pkg::ST_EMIT;
            lead_in = '0;
         end
         itf_pkg::ST_EMIT: begin
            lead_in = pad_s;
            zer_in = FW'(prec_s - size_s);
            case (seg_ff)
               itf_pkg::SEG_LEAD: begin
                  lim = r_ff.left_align ? '0 : pad_s;
                  if (cnt_ff < lim) begin put = 1'b1; ch = itf_pkg::CH_SPACE;
                     cnt_in = cnt_ff + 1'b1; end
                  else begin seg_in = itf_pkg::SEG_SIGN; cnt_in = '0; end
               end
               itf_pkg::SEG_SIGN: begin
                  if (sg_ff) begin put = 1'b1; ch = sgc_ff; end
                  seg_in = itf_pkg::SEG_PFX0;
               end
               itf_pkg::SEG_PFX0: begin
                  if (plen_ff != 2'd0) begin put = 1'b1; ch = itf_pkg::CH_ZERO; end
                  seg_in = itf_pkg::SEG_PFX1;
               end
               itf_pkg::SEG_PFX1: begin
                  if (plen_ff == 2'd2) begin
                     put = 1'b1;
                     if (rad_ff == 5'd2) ch = r_ff.upper_case ? 8'h42 : 8'h62;
                     else ch = r_ff.upper_case ? 8'h58 : 8'h78;
                  end
                  seg_in = itf_pkg::SEG_ZERO;
               end
               itf_pkg::SEG_ZERO: begin
                  if (cnt_ff < zer_in) begin put = 1'b1; ch = itf_pkg::CH_ZERO;
                     cnt_in = cnt_ff + 1'b1; end
                  else begin seg_in = itf_pkg::SEG_DIGIT; cnt_in = '0; end
               end
               itf_pkg::SEG_DIGIT: begin
                  put = 1'b1;
                  ch = itf_pkg::digit_char(dig_ff[3:0], r_ff.upper_case);
                  dig_in = dig_ff >> 4;
                  if (cnt_ff == FW'(nd_ff - 1'b1)) begin
                     seg_in = itf_pkg::SEG_TRAIL; cnt_in = '0;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               itf_pkg::SEG_TRAIL: begin
                  lim = r_ff.left_align ? pad_s : '0;
                  if (cnt_ff < lim) begin put = 1'b1; ch = itf_pkg::CH_SPACE;
                     cnt_in = cnt_ff + 1'b1; end
                  else seg_in = itf_pkg::SEG_DONE;
               end
               default: begin
                  last_in = 1'b1;
                  st_in = itf_pkg::ST_SEND;
               end
            endcase
            if (put) begin
               chunk_in[8*cc_ff[$clog2(CHUNK_CHARS > 1 ? CHUNK_CHARS : 2)-1:0] +: 8] = ch;
               cc_in = cc_ff + 1'b1;
               if (cc_ff == KW'(CHUNK_CHARS - 1)) st_in = itf_pkg::ST_SEND;
            end
         end
         itf_pkg::ST_SEND: begin
            if (rsp.ready) begin
               if (tail_done) st_in = itf_pkg::ST_IDLE;
               else st_in = itf_pkg::ST_EMIT;
               cc_in = '0; chunk_in = '0;
            end
         end
         default: st_in = itf_pkg::ST_IDLE;
      endcase
   end

   // a full chunk that closes the text is marked last when sent
   assign tail_done = last_ff || (seg_ff == itf_pkg::SEG_DONE) ||
      (seg_ff == itf_pkg::SEG_TRAIL && (r_ff.left_align ? cnt_ff >= lead_ff : 1'b1));

   always_comb begin
      rsp.payload = '0;
      rsp.payload.text_chunk = chunk_ff;
      rsp.payload.chunk_count = 4'(cc_ff);
      rsp.payload.last_chunk = tail_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= itf_pkg::ST_IDLE;
         seg_ff <= itf_pkg::SEG_LEAD;
         last_ff <= 1'b0;
         cc_ff <= '0;
         go_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         seg_ff <= (st_ff == itf_pkg::ST_SEND && rsp.ready && st_in == itf_pkg::ST_IDLE)
                   ? itf_pkg::SEG_LEAD : seg_in;
         last_ff <= last_in;
         cc_ff <= cc_in;
         go_ff <= go_in;
      end
      r_ff <= r_in; num_ff <= num_in; rad_ff <= rad_in; dig_ff <= dig_in;
      nd_ff <= nd_in; cnt_ff <= cnt_in; lead_ff <= lead_in; zer_ff <= zer_in;
      plen_ff <= plen_in; sg_ff <= sg_in; sgc_ff <= sgc_in; chunk_ff <= chunk_in;
   end

   a_cc_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (cc_ff != '0 && cc_ff <= KW'(CHUNK_CHARS))) else $error("chunk count");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("accept while sending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(chunk_ff))) else $error("hold");
endmodule
`default_nettype wire

/* verif/integer_text_formatter_unit_tb.sv */
// ----------------------------------------------------------------------------
// integer_text_formatter_unit_tb
// Self-checking bench for the integer text formatter. Number requests are
// rendered to padded text by a local predictor. The received text chunks are
// compared field by field against it, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module integer_text_formatter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FIELD_CAP   = 255;
   localparam int CHUNK_BYTES = 8;
   localparam int RANDOM_REQS = 340;
   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int LONG_HOLD   = 600;

   logic clock;
   logic reset;

   itf_if #(.payload_type(itf_pkg::req_type)) req_ch ();
   itf_if #(.payload_type(itf_pkg::rsp_type)) rsp_ch ();

   integer_text_formatter_unit u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   itf_pkg::req_type pending_reqs[$];
   itf_pkg::rsp_type expected_chunks[$];
   int      errors;
   int      reqs_sent;
   int      chunks_seen;
   int      cycles;
   int      send_gap;
   int      recv_hold;
   bit      long_hold_done;
   bit      req_taken;
   bit      rsp_taken;
   bit      stim_done;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH chunk %0d: %s got %h want %h", chunks_seen, what, got, want);
      errors++;
   endtask

   // renders one number to text and queues the chunks it should produce
   function automatic void render_number(input itf_pkg::req_type r);
      byte unsigned digs[$];
      byte unsigned txt[$];
      logic [63:0]  num;
      int           base, ndig, plen, size, width, prec, pad, d;
      byte unsigned sgn;
      bit           zpad;
      itf_pkg::rsp_type c;
      num   = r.value;
      base  = int'(r.radix);
      width = (r.field_width > FIELD_CAP) ? FIELD_CAP : int'(r.field_width);
      prec  = (r.min_length > FIELD_CAP) ? FIELD_CAP : int'(r.min_length);
      if (base < 2) base = 2;
      if (base > 16) base = 16;
      do begin
         d = int'(num % 64'(base));
         digs.push_front(8'((d < 10) ? 8'h30 + d : (r.upper_case ? 8'h41 : 8'h61) + d - 10));
         num = num / 64'(base);
      end while (num != 0);
      ndig = digs.size();
      plen = 0;
      if (r.want_prefix) begin
         if (base == 2 || base == 16) plen = 2;
         else if (base == 8) plen = 1;
      end
      sgn = 0;
      if (r.is_signed) begin
         if (r.is_negative) sgn = itf_pkg::CH_MINUS;
         else if (r.show_plus) sgn = itf_pkg::CH_PLUS;
         else if (r.space_sign) sgn = itf_pkg::CH_SPACE;
      end
      size = ndig + plen + ((sgn != 0) ? 1 : 0);
      zpad = r.zero_pad && !r.left_align;
      if (zpad && prec == 0) prec = width;
      if (size > prec) prec = size;
      pad = (width > prec) ? width - prec : 0;
      if (!r.left_align) repeat (pad) txt.push_back(itf_pkg::CH_SPACE);
      if (sgn != 0) txt.push_back(sgn);
      if (plen != 0) begin
         txt.push_back(itf_pkg::CH_ZERO);
         if (base == 2) txt.push_back(r.upper_case ? 8'h42 : 8'h62);
         else if (base == 16) txt.push_back(r.upper_case ? 8'h58 : 8'h78);
      end
      repeat (prec - size) txt.push_back(itf_pkg::CH_ZERO);
      foreach (digs[i]) txt.push_back(digs[i]);
      if (r.left_align) repeat (pad) txt.push_back(itf_pkg::CH_SPACE);
      for (int i = 0; i < txt.size(); i += CHUNK_BYTES) begin
         c = '0;
         for (int k = 0; k < CHUNK_BYTES && i + k < txt.size(); k++) begin
            c.text_chunk[8*k +: 8] = txt[i + k];
            c.chunk_count++;
         end
         c.last_chunk = (i + CHUNK_BYTES >= txt.size());
         expected_chunks.push_back(c);
      end
   endfunction

   function automatic itf_pkg::req_type random_req();
      itf_pkg::req_type r;
      int      sel;
      r = '0;
      sel = $urandom_range(0, 19);
      r.radix = (sel == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(2, 16));
      // long binary renderings are slow, so keep most values short
      if ($urandom_range(0, 5) == 0) r.value = {$urandom, $urandom};
      else r.value = {$urandom, $urandom} >> $urandom_range(24, 63);
      if ($urandom_range(0, 15) == 0) r.field_width = 8'($urandom_range(200, 255));
      else r.field_width = 8'($urandom_range(0, 40));
      case ($urandom_range(0, 3))
         0: r.min_length = 8'd0;
         1: r.min_length = 8'($urandom_range(0, 255));
         default: r.min_length = 8'($urandom_range(0, 30));
      endcase
      {r.want_prefix, r.is_signed, r.zero_pad, r.left_align, r.show_plus,
       r.space_sign, r.upper_case, r.is_negative} = 8'($urandom);
      return r;
   endfunction

   function automatic itf_pkg::req_type directed_req(input logic [63:0] v,
                                                     input logic [7:0] w,
                                                     input logic [7:0] p,
                                                     input logic [4:0] b,
                                                     input logic [7:0] flags);
      itf_pkg::req_type r;
      r = '0;
      r.value = v;
      r.field_width = w;
      r.min_length = p;
      r.radix = b;
      {r.want_prefix, r.is_signed, r.zero_pad, r.left_align, r.show_plus,
       r.space_sign, r.upper_case, r.is_negative} = flags;
      return r;
   endfunction

   // flags: prefix, signed, zero pad, left, plus, space, upper, negative
   initial begin
      pending_reqs.push_back(directed_req(64'd0, 8'd0, 8'd0, 5'd10, 8'b0000_0000));
      pending_reqs.push_back(directed_req('1, 8'd0, 8'd0, 5'd16, 8'b1000_0010));
      pending_reqs.push_back(directed_req('1, 8'd0, 8'd0, 5'd2, 8'b1000_0000));
      pending_reqs.push_back(directed_req(64'd255, 8'd12, 8'd0, 5'd8, 8'b1010_0000));
      pending_reqs.push_back(directed_req(64'd42, 8'd255, 8'd0, 5'd10, 8'b0100_0001));
      pending_reqs.push_back(directed_req(64'd42, 8'd10, 8'd255, 5'd10, 8'b0100_1000));
      pending_reqs.push_back(directed_req(64'd42, 8'd10, 8'd0, 5'd10, 8'b0111_1000));
      pending_reqs.push_back(directed_req(64'd42, 8'd10, 8'd0, 5'd10, 8'b0110_0100));
      pending_reqs.push_back(directed_req(64'd42, 8'd10, 8'd0, 5'd10, 8'b0100_1101));
      pending_reqs.push_back(directed_req(64'd42, 8'd10, 8'd0, 5'd10, 8'b0000_1101));
      pending_reqs.push_back(directed_req(64'd5, 8'd0, 8'd0, 5'd0, 8'b1000_0000));
      pending_reqs.push_back(directed_req(64'd5, 8'd0, 8'd0, 5'd1, 8'b1000_0000));
      pending_reqs.push_back(directed_req(64'hdead_beef, 8'd0, 8'd0, 5'd31, 8'b1000_0010));
      pending_reqs.push_back(directed_req(64'hdead_beef, 8'd0, 8'd0, 5'd17, 8'b1000_0000));
      pending_reqs.push_back(directed_req(64'd12345, 8'd20, 8'd2, 5'd10, 8'b1100_0000));
      pending_reqs.push_back(directed_req(64'd7, 8'd20, 8'd6, 5'd3, 8'b1110_0001));
      pending_reqs.push_back(directed_req(64'd99, 8'd3, 8'd8, 5'd16, 8'b1100_1010));
      pending_reqs.push_back(directed_req('1, 8'd255, 8'd255, 5'd7, 8'b1111_1111));
      pending_reqs.push_back(directed_req(64'd1, 8'd8, 8'd0, 5'd2, 8'b1010_0000));
      pending_reqs.push_back(directed_req(64'd0, 8'd16, 8'd0, 5'd8, 8'b1001_0000));
      repeat (RANDOM_REQS) pending_reqs.push_back(random_req());
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      req_taken <= req_ch.valid && req_ch.ready;
      rsp_taken <= rsp_ch.valid && rsp_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         render_number(req_ch.payload);
         reqs_sent++;
      end
   end

   // request driver with a random gap before each request
   always @(negedge clock) begin
      if (!reset && (!req_ch.valid || req_taken)) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_ch.payload <= pending_reqs.pop_front();
            req_ch.valid <= 1'b1;
            send_gap <= $urandom_range(0, 12);
         end else begin
            req_ch.valid <= 1'b0;
            stim_done <= 1'b1;
         end
      end
   end

   // response side: random stalls, one long hold-off while requests keep coming
   always @(negedge clock) begin
      int hold;
      if (!reset) begin
         if (!long_hold_done && reqs_sent >= 100) begin
            long_hold_done <= 1'b1;
            recv_hold <= LONG_HOLD;
            rsp_ch.ready <= 1'b0;
         end else if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_taken) begin
            hold = $urandom_range(0, 12);
            recv_hold <= (hold > 0) ? hold - 1 : 0;
            rsp_ch.ready <= (hold == 0);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      itf_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         chunks_seen++;
         if (expected_chunks.size() == 0) begin
            report_mismatch("unexpected chunk", rsp_ch.payload.text_chunk, '0);
         end else begin
            want = expected_chunks.pop_front();
            if (rsp_ch.payload.text_chunk !== want.text_chunk)
               report_mismatch("text_chunk", rsp_ch.payload.text_chunk, want.text_chunk);
            if (rsp_ch.payload.chunk_count !== want.chunk_count)
               report_mismatch("chunk_count", 64'(rsp_ch.payload.chunk_count),
                               64'(want.chunk_count));
            if (rsp_ch.payload.last_chunk !== want.last_chunk)
               report_mismatch("last_chunk", 64'(rsp_ch.payload.last_chunk),
                               64'(want.last_chunk));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d chunks outstanding", cycles,
                  expected_chunks.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      while (expected_chunks.size() != 0 || req_ch.valid) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Rendered %0d numbers into %0d text chunks over %0d cycles,", reqs_sent,
               chunks_seen, cycles);
      $display("covering all radices, padding modes, signs, prefixes and field limits.");
      if (errors == 0 && expected_chunks.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
